// ===== design/det4x4_schur_complement_defines.svh =====
// Assertion macros for the determinant block checker.
`ifndef DET4X4_SCHUR_COMPLEMENT_DEFINES_SVH
`define DET4X4_SCHUR_COMPLEMENT_DEFINES_SVH

// Implication checked on every rising clock edge, held off during reset.
`define DET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/d4sc_pkg.sv =====
`timescale 1ns / 1ps
package d4sc_pkg;
    localparam int ELEM_WIDTH_DEF = 12;
    localparam int IN_WIDTH       = 12;
    localparam int DET_WIDTH      = 50;
    localparam int MINOR_WIDTH    = 25;
    localparam int NUM_TERMS      = 6;

    // Control from sequencer to datapath.
    typedef struct packed {
        logic       mul_en;
        logic       sub_mode;   // product a-b: 1 subtracts second product
        logic       clr_acc;
        logic       acc_en;
        logic       acc_neg;    // term sign
        logic [1:0] i0;
        logic [1:0] j0;
        logic       bottom;
        logic       save_deta;
    } d4sc_ctrl_t;

    // Column pairs of the top minors per term, and each term's sign.
    function automatic logic [1:0] top_ci(input logic [2:0] t);
        case (t)
            3'd0, 3'd1, 3'd2: top_ci = 2'd0;
            3'd3, 3'd4:       top_ci = 2'd1;
            default:          top_ci = 2'd2;
        endcase
    endfunction
    function automatic logic [1:0] top_cj(input logic [2:0] t);
        case (t)
            3'd0:       top_cj = 2'd1;
            3'd1, 3'd3: top_cj = 2'd2;
            default:    top_cj = 2'd3;
        endcase
    endfunction
    function automatic logic term_neg(input logic [2:0] t);
        term_neg = (t == 3'd1) || (t == 3'd4);
    endfunction
endpackage

// ===== design/det4x4_schur_complement.sv =====
`timescale 1ns / 1ps
// Rows one to three are taken one item a cycle while the sequencer is idle; the
// fourth row starts the sequencer, and no new row is taken until it finishes
// (it finishes early when the leading block is singular). The single shared
// multiplier is run for 24 minor and 6 product multiplies.
// Reset: rst_n async low clears row count, sequencer and output valid.
module det4x4_schur_complement
    import d4sc_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [IN_WIDTH-1:0]   col0,
    input  logic signed [IN_WIDTH-1:0]   col1,
    input  logic signed [IN_WIDTH-1:0]   col2,
    input  logic signed [IN_WIDTH-1:0]   col3,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DET_WIDTH-1:0]  determinant,
    output logic                         singular_block
);
    logic [1:0]  row_count_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    logic signed [DET_WIDTH-1:0] det_reg;
    logic        sing_reg;
    logic        accept, start, done, deta_zero;
    d4sc_ctrl_t  ctrl;
    logic signed [DET_WIDTH-1:0] det_w;
    logic        prod_phase;

    // Busy from the fourth row until the sequencer finishes. Rows one to
    // three load while a result waits; only the fourth row waits for it.
    assign in_stall = busy_reg || (out_valid_reg && (row_count_reg == 2'd3));
    assign accept   = in_valid && !in_stall;
    assign start    = accept && (row_count_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                row_count_reg <= row_count_reg + 2'd1;
            if (start)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
            if (done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            det_reg  <= deta_zero ? '0 : det_w;
            sing_reg <= deta_zero;
        end
    end

    // The product step: sequencer signals it by neither multiply nor accumulate enable active.
    assign prod_phase = busy_reg && !ctrl.mul_en && !ctrl.acc_en && !done;

    d4sc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .deta_zero (deta_zero),
        .ctrl      (ctrl),
        .done      (done)
    );

    d4sc_dp #(.ELEM_WIDTH(ELEM_WIDTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .row        (row_count_reg),
        .e0         (col0[ELEM_WIDTH-1:0]),
        .e1         (col1[ELEM_WIDTH-1:0]),
        .e2         (col2[ELEM_WIDTH-1:0]),
        .e3         (col3[ELEM_WIDTH-1:0]),
        .ctrl       (ctrl),
        .prod_phase (prod_phase),
        .deta_zero  (deta_zero),
        .det        (det_w)
    );

    assign out_valid      = out_valid_reg;
    assign determinant    = det_reg;
    assign singular_block = sing_reg;
endmodule

// ===== design/d4sc_seq.sv =====
`timescale 1ns / 1ps
module d4sc_seq
    import d4sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       deta_zero,
    output d4sc_ctrl_t ctrl,
    output logic       done
);
    // Per term: minor top (2 half steps), minor bottom, product, accumulate.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TOP  = 6'b000010,
        S_BOT  = 6'b000100,
        S_PROD = 6'b001000,
        S_ACC  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] term_reg, term_next;
    logic       half_reg, half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            half_reg  <= half_next;
        end
    end

    always_comb
    begin
        logic [1:0] ci, cj;
        ci = top_ci(term_reg);
        cj = top_cj(term_reg);
        state_next = state_reg;
        term_next  = term_reg;
        half_next  = half_reg;
        ctrl       = '0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_TOP;
                    term_next  = '0;
                    half_next  = 1'b0;
                end
            end
            S_TOP, S_BOT:
            begin
                // minor = p[i]q[j] - p[j]q[i], two multiplies
                ctrl.mul_en   = 1'b1;
                ctrl.bottom   = (state_reg == S_BOT);
                ctrl.sub_mode = half_reg;
                if (state_reg == S_TOP)
                begin
                    ctrl.i0 = ci;
                    ctrl.j0 = cj;
                end
                else
                begin
                    // complementary columns
                    ctrl.i0 = 2'd3 - cj;
                    ctrl.j0 = 2'd3 - ci;
                    if (term_reg == 3'd2 || term_reg == 3'd3)
                    begin
                        ctrl.i0 = (term_reg == 3'd2) ? 2'd1 : 2'd0;
                        ctrl.j0 = (term_reg == 3'd2) ? 2'd2 : 2'd3;
                    end
                end
                ctrl.save_deta = (state_reg == S_TOP) && half_reg && (term_reg == 3'd0);
                half_next = !half_reg;
                if (half_reg)
                    state_next = (state_reg == S_TOP) ? S_BOT : S_PROD;
            end
            S_PROD:
            begin
                if (deta_zero)
                    state_next = S_DONE;
                else
                begin
                    ctrl.clr_acc = (term_reg == 3'd0);
                    state_next   = S_ACC;
                end
            end
            S_ACC:
            begin
                ctrl.acc_en  = 1'b1;
                ctrl.acc_neg = term_neg(term_reg);
                if (term_reg == 3'(NUM_TERMS - 1))
                    state_next = S_DONE;
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = S_TOP;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== design/d4sc_dp.sv =====
`timescale 1ns / 1ps
module d4sc_dp
    import d4sc_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [1:0]                   row,
    input  logic signed [ELEM_WIDTH-1:0] e0,
    input  logic signed [ELEM_WIDTH-1:0] e1,
    input  logic signed [ELEM_WIDTH-1:0] e2,
    input  logic signed [ELEM_WIDTH-1:0] e3,
    input  d4sc_ctrl_t                   ctrl,
    input  logic                         prod_phase,
    output logic                         deta_zero,
    output logic signed [DET_WIDTH-1:0]  det
);
    logic signed [ELEM_WIDTH-1:0] mat_reg [16];
    logic signed [MINOR_WIDTH-1:0] part_reg, top_reg, bot_reg;
    logic signed [DET_WIDTH-1:0]   prod_reg, acc_reg;
    logic                          dz_reg;

    // Operand fetch for the one shared multiplier.
    logic [1:0]                    ra, rb;
    logic [1:0]                    ca, cb;
    logic signed [MINOR_WIDTH-1:0] opa, opb;
    logic signed [DET_WIDTH-1:0]   mul;

    always_comb
    begin
        ra = ctrl.bottom ? 2'd2 : 2'd0;
        rb = ctrl.bottom ? 2'd3 : 2'd1;
        ca = ctrl.sub_mode ? ctrl.j0 : ctrl.i0;
        cb = ctrl.sub_mode ? ctrl.i0 : ctrl.j0;
        if (prod_phase)
        begin
            opa = top_reg;
            opb = bot_reg;
        end
        else
        begin
            opa = MINOR_WIDTH'(mat_reg[{ra, ca}]);
            opb = MINOR_WIDTH'(mat_reg[{rb, cb}]);
        end
        mul = DET_WIDTH'(opa) * DET_WIDTH'(opb);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg[{row, 2'd0}] <= e0;
            mat_reg[{row, 2'd1}] <= e1;
            mat_reg[{row, 2'd2}] <= e2;
            mat_reg[{row, 2'd3}] <= e3;
        end
        if (ctrl.mul_en)
        begin
            if (!ctrl.sub_mode)
                part_reg <= MINOR_WIDTH'(mul);
            else if (ctrl.bottom)
                bot_reg <= part_reg - MINOR_WIDTH'(mul);
            else
                top_reg <= part_reg - MINOR_WIDTH'(mul);
        end
        if (prod_phase)
            prod_reg <= mul;
        if (ctrl.clr_acc)
            acc_reg <= '0;
        else if (ctrl.acc_en)
            acc_reg <= ctrl.acc_neg ? acc_reg - prod_reg : acc_reg + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dz_reg <= 1'b0;
        else if (ctrl.save_deta)
            dz_reg <= ((part_reg - MINOR_WIDTH'(mul)) == '0);
    end

    // clr happens in the product cycle of term 0, so first accumulate adds to zero
    assign deta_zero = dz_reg;
    assign det       = acc_reg;
endmodule

// ===== design/d4sc_checker.sv =====
`timescale 1ns / 1ps
`include "det4x4_schur_complement_defines.svh"
module d4sc_checker
    import d4sc_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [DET_WIDTH-1:0] determinant,
    input logic                        singular_block
);
    `DET_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && singular_block, determinant == '0, "singular result not zero")
    `DET_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(determinant), "stalled result changed")
    `DET_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "stalled item dropped")
    `DET_ASSERT_NXT(a_no_repeat, clk, rst_n, out_valid && !out_stall, !out_valid, "result repeated")
endmodule

bind det4x4_schur_complement d4sc_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .determinant    (determinant),
    .singular_block (singular_block)
);
